/* hw/rtl/dlps_pkg.sv */
// dlps_pkg: shared constants, register codes and control structs for the
// dashed line point stepper and its shared divide / square-root unit.
// No dependencies.
package dlps_pkg;

  // default coordinate width, dash and gap length width, cycle length width
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned LEN_BITS       = 12;
  localparam int unsigned CYC_BITS       = LEN_BITS + 1;

  // configuration port widths
  localparam int unsigned IDX_BITS       = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_START_X  = 3'd0,
    REG_START_Y  = 3'd1,
    REG_END_X    = 3'd2,
    REG_END_Y    = 3'd3,
    REG_DASH_LEN = 3'd4,
    REG_GAP_LEN  = 3'd5
  } cfg_reg_e;

  // operations of the shared arithmetic unit
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_e;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  // status from the arithmetic unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

endpackage

/* hw/rtl/dashed_line_point_stepper.sv */
// dashed_line_point_stepper: top level, config registers, point sequencer,
// shared multiplier and result register.
// Depends on dlps_pkg and dlps_arith.
//
//  channel  | direction | handshake                        | contents
//  s_axis   | in        | s_axis_tvalid_i / s_axis_tready_o | tick item, restart flag
//  m_axis   | out       | m_axis_tvalid_o / m_axis_tready_i | point, draw flag, last flag
//  cfg      | in        | cfg_valid_i / cfg_ready_o         | register index and value
//
// a tick makes five bit-serial passes of the shared divide / square-root unit:
// line length, minor offset, distance from start, and two dash-cycle
// remainders. a line with equal endpoints makes none of them.
// reset clears the configuration registers to zero and the step counter to step zero.
// s_axis_tready_o is high only while no tick is in progress; a finished
// point waits in the output register while the next tick is taken.
module dashed_line_point_stepper #(
  parameter int unsigned COORD_BITS = dlps_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick input
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,  // [0] restart
  // point output
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata_o,  // point_x, point_y
  output logic [0:0]                         m_axis_tuser_o,  // draw
  output logic                               m_axis_tlast_o,  // is_last
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dlps_pkg::IDX_BITS-1:0]      cfg_index_i,
  input  logic [dlps_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned SB  = CB + 1;
  localparam int unsigned RW  = 2 * SB;
  localparam int unsigned PW  = 2 * CB;
  localparam int unsigned CYB = dlps_pkg::CYC_BITS;
  localparam int unsigned LB  = dlps_pkg::LEN_BITS;
  localparam int unsigned DW  = (SB > CYB) ? SB : CYB;
  localparam int unsigned TDW = ((2 * CB + 7) / 8) * 8;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_GEOM   = 13'b0000000000010,
    S_SQX    = 13'b0000000000100,
    S_SQY    = 13'b0000000001000,
    S_LSTART = 13'b0000000010000,
    S_LWAIT  = 13'b0000000100000,
    S_OFF    = 13'b0000001000000,
    S_OSQ    = 13'b0000010000000,
    S_DSTART = 13'b0000100000000,
    S_DWAIT  = 13'b0001000000000,
    S_MD     = 13'b0010000000000,
    S_ML     = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CB-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [LB-1:0] dash_len_q, gap_len_q;

  // step counter
  logic [CB-1:0] step_q;

  // per-tick working registers
  logic          restart_q;
  logic [SB-1:0] dx_q, dy_q;
  logic [CB-1:0] adx_q, ady_q;
  logic [CB-1:0] m_q, mabs_q, k_q, off_q;
  logic          xmaj_q, mneg_q, majneg_q;
  logic [PW-1:0] prod_q, sum_q;
  logic [SB-1:0] total_q, d_q;
  logic [CYB-1:0] dmod_q, tm_q;

  // result register
  logic          out_valid_q;
  logic [CB-1:0] out_x_q, out_y_q;
  logic          out_draw_q, out_last_q;

  logic          in_acc, out_load;
  logic [SB-1:0] adx_c, ady_c;
  logic          xmaj_c;
  logic [CB-1:0] mul_a, mul_b;
  logic [RW-1:0] p2, mm, numer;
  logic [CYB-1:0] cyc;
  logic [CB-1:0] kdelta, odelta;
  logic [CB-1:0] out_x_d, out_y_d;
  logic          out_draw_d, out_last_d;
  logic          in_dash, final_dash;

  dlps_pkg::arith_req_t arith_req;
  dlps_pkg::arith_sts_t arith_sts;
  logic [RW-1:0]        arith_num;
  logic [DW-1:0]        arith_den;
  logic [SB-1:0]        arith_quot;
  logic [DW-1:0]        arith_rem;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign cyc             = {1'b0, dash_len_q} + {1'b0, gap_len_q};

  // configuration writes, out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q  <= '0;
      start_y_q  <= '0;
      end_x_q    <= '0;
      end_y_q    <= '0;
      dash_len_q <= '0;
      gap_len_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (dlps_pkg::cfg_reg_e'(cfg_index_i))
        dlps_pkg::REG_START_X:  start_x_q  <= cfg_data_i[CB-1:0];
        dlps_pkg::REG_START_Y:  start_y_q  <= cfg_data_i[CB-1:0];
        dlps_pkg::REG_END_X:    end_x_q    <= cfg_data_i[CB-1:0];
        dlps_pkg::REG_END_Y:    end_y_q    <= cfg_data_i[CB-1:0];
        dlps_pkg::REG_DASH_LEN: dash_len_q <= cfg_data_i[LB-1:0];
        dlps_pkg::REG_GAP_LEN:  gap_len_q  <= cfg_data_i[LB-1:0];
        default: ;
      endcase
    end
  end

  // absolute deltas and major axis choice, ties go to y
  always_comb begin
    adx_c  = dx_q[SB-1] ? (SB'(0) - dx_q) : dx_q;
    ady_c  = dy_q[SB-1] ? (SB'(0) - dy_q) : dy_q;
    xmaj_c = (adx_c > ady_c);
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = k_q;
    mul_b = k_q;
    if (state_q == S_SQX) begin
      mul_a = adx_q;
      mul_b = adx_q;
    end else if (state_q == S_SQY) begin
      mul_a = ady_q;
      mul_b = ady_q;
    end else if (state_q == S_LSTART || state_q == S_LWAIT) begin
      mul_a = mabs_q;
      mul_b = k_q;
    end else if (state_q == S_OSQ) begin
      mul_a = arith_quot[CB-1:0];
      mul_b = arith_quot[CB-1:0];
    end
  end

  // rounding numerator 2*m*k + M, or 2*m*k - M clamped at zero for a negative minor delta
  always_comb begin
    p2 = {1'b0, prod_q, 1'b0};
    mm = RW'(m_q);
    if (mneg_q) begin
      numer = (p2 >= mm) ? (p2 - mm) : '0;
    end else begin
      numer = p2 + mm;
    end
  end

  // sequencer and arithmetic unit requests
  always_comb begin
    state_d       = state_q;
    arith_req     = '{start: 1'b0, op: dlps_pkg::OP_DIV};
    arith_num     = '0;
    arith_den     = '0;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_GEOM;
      S_GEOM:   state_d = S_SQX;
      S_SQX:    state_d = (m_q == '0) ? S_FIN : S_SQY;
      S_SQY:    state_d = S_LSTART;
      S_LSTART: begin
        arith_req = '{start: 1'b1, op: dlps_pkg::OP_SQRT};
        arith_num = RW'(sum_q) + RW'(prod_q);
        state_d   = S_LWAIT;
      end
      S_LWAIT: begin
        if (arith_sts.done) begin
          arith_req = '{start: 1'b1, op: dlps_pkg::OP_DIV};
          arith_num = numer;
          arith_den = DW'({m_q, 1'b0});
          state_d   = S_OFF;
        end
      end
      S_OFF:    if (arith_sts.done) state_d = S_OSQ;
      S_OSQ:    state_d = S_DSTART;
      S_DSTART: begin
        arith_req = '{start: 1'b1, op: dlps_pkg::OP_SQRT};
        arith_num = RW'(sum_q) + RW'(prod_q);
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (arith_sts.done) begin
          arith_req = '{start: 1'b1, op: dlps_pkg::OP_DIV};
          arith_num = RW'(arith_quot);
          arith_den = DW'(cyc);
          state_d   = S_MD;
        end
      end
      S_MD: begin
        if (arith_sts.done) begin
          arith_req = '{start: 1'b1, op: dlps_pkg::OP_DIV};
          arith_num = RW'(total_q);
          arith_den = DW'(cyc);
          state_d   = S_ML;
        end
      end
      S_ML:     if (arith_sts.done) state_d = S_FIN;
      S_FIN:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // dash rule, solid when either length is zero or the line is one point
  always_comb begin
    in_dash    = (dmod_q < CYB'(dash_len_q));
    final_dash = (tm_q >= CYB'(dash_len_q)) &&
                 (DW'(d_q) > (DW'(total_q) - DW'(tm_q)));
    out_draw_d = (dash_len_q == '0) || (gap_len_q == '0) || (m_q == '0) ||
                 in_dash || final_dash;
  end

  // point coordinates from step and offset
  always_comb begin
    kdelta     = majneg_q ? (CB'(0) - k_q) : k_q;
    odelta     = mneg_q ? (CB'(0) - off_q) : off_q;
    out_x_d    = xmaj_q ? (start_x_q + kdelta) : (start_x_q + odelta);
    out_y_d    = xmaj_q ? (start_y_q + odelta) : (start_y_q + kdelta);
    out_last_d = (k_q == m_q);
  end

  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        step_q      <= (k_q < m_q) ? (k_q + 1'b1) : m_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= {{CB{1'b0}}, mul_a} * {{CB{1'b0}}, mul_b};
    if (in_acc) begin
      restart_q <= s_axis_tdata_i[0];
      dx_q      <= {end_x_q[CB-1], end_x_q} - {start_x_q[CB-1], start_x_q};
      dy_q      <= {end_y_q[CB-1], end_y_q} - {start_y_q[CB-1], start_y_q};
    end
    if (state_q == S_GEOM) begin
      adx_q    <= adx_c[CB-1:0];
      ady_q    <= ady_c[CB-1:0];
      xmaj_q   <= xmaj_c;
      m_q      <= xmaj_c ? adx_c[CB-1:0] : ady_c[CB-1:0];
      mabs_q   <= xmaj_c ? ady_c[CB-1:0] : adx_c[CB-1:0];
      mneg_q   <= xmaj_c ? dy_q[SB-1] : dx_q[SB-1];
      majneg_q <= xmaj_c ? dx_q[SB-1] : dy_q[SB-1];
    end
    if (state_q == S_SQX) begin
      k_q   <= restart_q ? '0 : ((step_q > m_q) ? m_q : step_q);
      off_q <= '0;
    end
    if (state_q == S_SQY || state_q == S_OSQ) begin
      sum_q <= prod_q;
    end
    if (state_q == S_LWAIT && arith_sts.done) begin
      total_q <= arith_quot;
    end
    if (state_q == S_OFF && arith_sts.done) begin
      off_q <= arith_quot[CB-1:0];
    end
    if (state_q == S_DWAIT && arith_sts.done) begin
      d_q <= arith_quot;
    end
    if (state_q == S_MD && arith_sts.done) begin
      dmod_q <= arith_rem[CYB-1:0];
    end
    if (state_q == S_ML && arith_sts.done) begin
      tm_q <= arith_rem[CYB-1:0];
    end
    if (out_load) begin
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_draw_q <= out_draw_d;
      out_last_q <= out_last_d;
    end
  end

  // shared divide / square-root unit
  dlps_arith #(
    .SB (SB),
    .DW (DW)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .num_i  (arith_num),
    .den_i  (arith_den),
    .sts_o  (arith_sts),
    .quot_o (arith_quot),
    .rem_o  (arith_rem)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDW'({out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_draw_q;
  assign m_axis_tlast_o  = out_last_q;

  // the sequencer never restarts the unit mid-operation
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_req.start |-> !arith_sts.busy)
    else $error("arith unit started while busy");

  // unit results only arrive while the sequencer waits for them
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_sts.done |-> (state_q == S_LWAIT || state_q == S_OFF ||
                        state_q == S_DWAIT || state_q == S_MD || state_q == S_ML))
    else $error("arith result arrived outside a wait state");

  // a one-point line is always drawn and always last
  a_degen_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && m_q == '0) |-> (out_draw_d && out_last_d))
    else $error("single point line not drawn as last point");

  // a loaded point is offered on the next cycle
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o)
    else $error("loaded point not presented");

endmodule

/* hw/rtl/dlps_arith.sv */
// dlps_arith: shared bit-serial unit for restoring division / modulo and
// floor integer square root, one result bit per cycle.
// Depends on dlps_pkg (op codes, request and status structs).
module dlps_arith #(
  parameter int unsigned SB = dlps_pkg::COORD_BITS_DEF + 1,
  parameter int unsigned DW = dlps_pkg::CYC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlps_pkg::arith_req_t req_i,
  input  logic [2*SB-1:0]      num_i,   // dividend or radicand
  input  logic [DW-1:0]        den_i,   // divisor, unused for square root
  output dlps_pkg::arith_sts_t sts_o,
  output logic [SB-1:0]        quot_o,  // quotient or root
  output logic [DW-1:0]        rem_o    // remainder of a division
);

  localparam int unsigned RW = 2 * SB;
  localparam int unsigned AW = (DW + 1 > SB + 3) ? DW + 1 : SB + 3;
  localparam int unsigned CW = $clog2(SB + 1);

  logic [AW-1:0]       acc_q;
  logic [RW-1:0]       sh_q;
  logic [SB-1:0]       q_q;
  logic [DW-1:0]       den_q;
  dlps_pkg::arith_op_e op_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [AW-1:0]       trial_a;
  logic [AW-1:0]       trial_b;
  logic [AW-1:0]       diff;
  logic                ge;

  // one trial subtraction per cycle, shared by both operations
  always_comb begin
    unique case (op_q)
      dlps_pkg::OP_DIV: begin
        trial_a = {acc_q[AW-2:0], sh_q[RW-1]};
        trial_b = AW'(den_q);
      end
      dlps_pkg::OP_SQRT: begin
        trial_a = {acc_q[AW-3:0], sh_q[RW-1 -: 2]};
        trial_b = AW'({q_q, 2'b01});
      end
      default: begin
        trial_a = '0;
        trial_b = '0;
      end
    endcase
    diff = trial_a - trial_b;
    ge   = (trial_a >= trial_b);
  end

  // step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(SB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: division starts with the upper half already in the remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      den_q <= den_i;
      q_q   <= '0;
      if (req_i.op == dlps_pkg::OP_DIV) begin
        acc_q <= AW'(num_i[RW-1:SB]);
        sh_q  <= {num_i[SB-1:0], {SB{1'b0}}};
      end else begin
        acc_q <= '0;
        sh_q  <= num_i;
      end
    end else if (busy_q) begin
      acc_q <= ge ? diff : trial_a;
      q_q   <= {q_q[SB-2:0], ge};
      if (op_q == dlps_pkg::OP_DIV) begin
        sh_q <= {sh_q[RW-2:0], 1'b0};
      end else begin
        sh_q <= {sh_q[RW-3:0], 2'b00};
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = q_q;
  assign rem_o      = acc_q[DW-1:0];

  // done is a single pulse per operation
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("arith done held longer than one cycle");

  // a running operation always has steps left
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("arith busy with zero step count");

  // a start always puts the unit into the busy state
  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("arith start did not begin an operation");

endmodule
